// ===== sv/kst_pkg.sv =====
`timescale 1ns / 1ps
package kst_pkg;

   localparam int ENTRIES = 32;
   localparam int IDX_W = $clog2(ENTRIES);
   localparam int SLOT_W = 5;
   localparam int KEY_WIDE_W = 64;
   localparam int KEY_HIGH_W = 32;
   localparam int LEVEL_W = 16;
   localparam int LIVES_W = 8;
   localparam int OP_W = 2;
   localparam int STATUS_W = 2;
   localparam int REQ_FIELDS_W = OP_W + 2 * KEY_WIDE_W + KEY_HIGH_W + LEVEL_W + LIVES_W;
   localparam int REQ_TDATA_W = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = STATUS_W + SLOT_W + LEVEL_W + LIVES_W;
   localparam int RSP_TDATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_REMOVE = 2'd2
   } kst_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } kst_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } kst_state_type;

   typedef struct packed {
      logic [KEY_WIDE_W-1:0] key_low;
      logic [KEY_WIDE_W-1:0] key_mid;
      logic [KEY_HIGH_W-1:0] key_high;
      logic [LEVEL_W-1:0]    level;
      logic [LIVES_W-1:0]    lives;
   } kst_entry_type;

   typedef struct packed {
      kst_op_type    op;
      kst_entry_type entry;
   } kst_cmd_type;

   typedef struct packed {
      kst_status_type    status;
      logic [SLOT_W-1:0] slot;
      logic [LEVEL_W-1:0] level;
      logic [LIVES_W-1:0] lives;
   } kst_rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      kst_entry_type     wr_data;
      logic [IDX_W-1:0]  rd_addr;
   } kst_mem_req_type;

endpackage

// ===== sv/kst_store.sv =====
`timescale 1ns / 1ps
module kst_store (
   input  logic                     clock,
   input  kst_pkg::kst_mem_req_type mem_req,
   output kst_pkg::kst_entry_type   rd_data
);
   import kst_pkg::*;

   kst_entry_type mem [0:ENTRIES-1];
   kst_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= mem[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/kst_scan.sv =====
`timescale 1ns / 1ps
module kst_scan (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  kst_pkg::kst_cmd_type     req_item,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output kst_pkg::kst_rsp_type     rsp_item,
   output kst_pkg::kst_mem_req_type mem_req,
   input  kst_pkg::kst_entry_type   rd_data
);
   import kst_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   kst_state_type      state_ff, state_in;
   kst_cmd_type        cmd_ff, cmd_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic               issue_done_ff, issue_done_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   kst_rsp_type        res_ff, res_in;
   kst_rsp_type        rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               key_eq;
   logic               hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      cnt_ff        <= cnt_in;
      issue_done_ff <= issue_done_in;
      pend_idx_ff   <= pend_idx_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
   end

   assign key_eq = (rd_data.key_low == cmd_ff.entry.key_low) &&
                   (rd_data.key_mid == cmd_ff.entry.key_mid) &&
                   (rd_data.key_high == cmd_ff.entry.key_high);

   always_comb begin
      state_in         = state_ff;
      cmd_in           = cmd_ff;
      cnt_in           = cnt_ff;
      issue_done_in    = issue_done_ff;
      pend_in          = 1'b0;
      pend_idx_in      = pend_idx_ff;
      valid_in         = valid_ff;
      res_in           = res_ff;
      rsp_in           = rsp_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      req_ready        = 1'b0;
      hit              = 1'b0;
      mem_req.wr_en    = 1'b0;
      mem_req.wr_addr  = pend_idx_ff;
      mem_req.wr_data  = cmd_ff.entry;
      mem_req.rd_addr  = cnt_ff;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in        = req_item;
               cnt_in        = '0;
               issue_done_in = 1'b0;
               res_in.status = ST_OK;
               res_in.slot   = '0;
               res_in.level  = '0;
               res_in.lives  = '0;
               if (req_item.op == OP_INSERT || req_item.op == OP_LOOKUP ||
                   req_item.op == OP_REMOVE) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            if (!issue_done_ff) begin
               pend_in     = 1'b1;
               pend_idx_in = cnt_ff;
               if (cnt_ff == LAST_IDX) begin
                  issue_done_in = 1'b1;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            if (pend_ff) begin
               if (cmd_ff.op == OP_INSERT) begin
                  hit = !valid_ff[pend_idx_ff];
               end else begin
                  hit = valid_ff[pend_idx_ff] && key_eq;
               end
               if (hit) begin
                  pend_in     = 1'b0;
                  state_in    = S_DONE;
                  res_in.slot = SLOT_W'(pend_idx_ff);
                  unique case (cmd_ff.op)
                     OP_INSERT: begin
                        mem_req.wr_en         = 1'b1;
                        valid_in[pend_idx_ff] = 1'b1;
                     end
                     OP_LOOKUP: begin
                        res_in.level = rd_data.level;
                        res_in.lives = rd_data.lives;
                     end
                     OP_REMOVE: begin
                        valid_in[pend_idx_ff] = 1'b0;
                     end
                     default: begin
                     end
                  endcase
               end else if (pend_idx_ff == LAST_IDX) begin
                  pend_in  = 1'b0;
                  state_in = S_DONE;
                  res_in.status = (cmd_ff.op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_write_free_slot: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> !valid_ff[mem_req.wr_addr])
      else $error("insert wrote an occupied slot");

   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |=> valid_ff[$past(mem_req.wr_addr)])
      else $error("inserted slot not marked valid");

   a_valid_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_SCAN) |=> $stable(valid_ff))
      else $error("valid flags changed outside a scan");

   a_pend_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == S_SCAN))
      else $error("pending compare outside a scan");

   a_full_means_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && res_ff.status == ST_FULL) |-> (&valid_ff))
      else $error("table full reported with a free slot");
`endif

endmodule

// ===== sv/keyed_slot_table.sv =====
`timescale 1ns / 1ps
// Keyed slot table: 32 slots, each a 160-bit key with a level and a lives value.
// Commands arrive on the req_ stream: insert takes the lowest free slot,
// lookup returns the lowest valid slot whose key matches, remove clears it.
// Every command gives exactly one transfer on the rsp_ stream with a status
// (ok, table full, key not found), the slot number and, on lookup, the values.
// Commands are handled one at a time: req_tready is high only while the block
// is idle. The scan visits one slot per cycle through the key memory's single
// registered read port and the 160-bit key comparator; a hit ends the scan at
// slot k, a miss or a full table ends it only after the last slot, and the
// unused opcode skips the scan.
// The next command can be taken in the cycle after the result is loaded.
// The result sits in an output register; if the receiver stalls, the block still
// takes and scans the next command and holds its result until the register frees.
// Reset clears all valid flags and the handshake state; the table is empty and
// ready right after reset, with no clearing pass.
module keyed_slot_table (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // opcode, key_low, key_mid, key_high, level_in, lives_in
   input  logic [kst_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status, slot_index, level_out, lives_out
   output logic [kst_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import kst_pkg::*;

   localparam int KL_LO = OP_W;
   localparam int KM_LO = KL_LO + KEY_WIDE_W;
   localparam int KH_LO = KM_LO + KEY_WIDE_W;
   localparam int LV_LO = KH_LO + KEY_HIGH_W;
   localparam int LF_LO = LV_LO + LEVEL_W;

   kst_cmd_type     req_item;
   kst_rsp_type     rsp_item;
   kst_mem_req_type mem_req;
   kst_entry_type   rd_data;

   assign req_item.op             = kst_op_type'(req_tdata[OP_W-1:0]);
   assign req_item.entry.key_low  = req_tdata[KL_LO +: KEY_WIDE_W];
   assign req_item.entry.key_mid  = req_tdata[KM_LO +: KEY_WIDE_W];
   assign req_item.entry.key_high = req_tdata[KH_LO +: KEY_HIGH_W];
   assign req_item.entry.level    = req_tdata[LV_LO +: LEVEL_W];
   assign req_item.entry.lives    = req_tdata[LF_LO +: LIVES_W];

   assign rsp_tdata = {(RSP_TDATA_W - RSP_FIELDS_W)'(0), rsp_item.lives, rsp_item.level,
                       rsp_item.slot, rsp_item.status};

   kst_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   kst_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_item  (req_item),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item),
      .mem_req   (mem_req),
      .rd_data   (rd_data)
   );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import kst_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
   localparam int KEY_W = 2 * KEY_WIDE_W + KEY_HIGH_W;
   localparam int POOL_SIZE = 16;
   localparam int RANDOM_COMMANDS = 1530;
   localparam int TAIL_COMMANDS = 150;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      logic [OP_W-1:0]       op;
      logic [KEY_WIDE_W-1:0] key_low;
      logic [KEY_WIDE_W-1:0] key_mid;
      logic [KEY_HIGH_W-1:0] key_high;
      logic [LEVEL_W-1:0]    level;
      logic [LIVES_W-1:0]    lives;
   } command_type;

   typedef struct {
      kst_status_type     status;
      logic [SLOT_W-1:0]  slot;
      logic [LEVEL_W-1:0] level;
      logic [LIVES_W-1:0] lives;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   keyed_slot_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // table shadow
   logic               slot_used  [ENTRIES];
   logic [KEY_W-1:0]   slot_key   [ENTRIES];
   logic [LEVEL_W-1:0] slot_level [ENTRIES];
   logic [LIVES_W-1:0] slot_lives [ENTRIES];

   command_type pending_q [$];
   outcome_type expected_q [$];
   command_type cmd_on_bus;
   outcome_type due;
   logic [KEY_W-1:0] key_pool [POOL_SIZE];

   int   command_total = 0;
   int   accepted_count = 0;
   int   error_count = 0;
   int   op_count [4] = '{0, 0, 0, 0};
   int   status_count [4] = '{0, 0, 0, 0};
   bit   req_taken = 1'b0;
   bit   steady = 1'b0;
   bit   tail_phase = 1'b0;
   int   req_gap = 0;
   int   rsp_gap = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("keyed_slot_table regression: fail");
      $finish;
   end

   task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      error_count++;
      $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
   endtask

   function automatic outcome_type apply_table_command(command_type c);
      outcome_type r;
      logic [KEY_W-1:0] k;
      int hit;
      int s;
      r.status = ST_OK;
      r.slot = '0;
      r.level = '0;
      r.lives = '0;
      k = {c.key_high, c.key_mid, c.key_low};
      hit = -1;
      case (c.op)
         OP_INSERT: begin
            for (s = 0; s < ENTRIES; s++)
               if (!slot_used[s] && hit < 0) hit = s;
            if (hit < 0) begin
               r.status = ST_FULL;
            end else begin
               slot_used[hit] = 1'b1;
               slot_key[hit] = k;
               slot_level[hit] = c.level;
               slot_lives[hit] = c.lives;
               r.slot = hit[SLOT_W-1:0];
            end
         end
         OP_LOOKUP, OP_REMOVE: begin
            for (s = 0; s < ENTRIES; s++)
               if (slot_used[s] && slot_key[s] == k && hit < 0) hit = s;
            if (hit < 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               r.slot = hit[SLOT_W-1:0];
               if (c.op == OP_LOOKUP) begin
                  r.level = slot_level[hit];
                  r.lives = slot_lives[hit];
               end else begin
                  slot_used[hit] = 1'b0;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic queue_command(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                                logic [LEVEL_W-1:0] level, logic [LIVES_W-1:0] lives);
      command_type c;
      c.op = op;
      c.key_low = k[KEY_WIDE_W-1:0];
      c.key_mid = k[2*KEY_WIDE_W-1:KEY_WIDE_W];
      c.key_high = k[KEY_W-1:2*KEY_WIDE_W];
      c.level = level;
      c.lives = lives;
      pending_q.push_back(c);
   endtask

   function automatic logic [KEY_W-1:0] random_key();
      return {$urandom, $urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      logic [KEY_W-1:0] k;
      int roll;
      roll = $urandom_range(0, 99);
      k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (roll >= 85)
         k = random_key();
      else if (roll >= 70)
         k[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
      return k;
   endfunction

   // hold valid until the transfer, then advance or idle
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            req_taken = 1'b0;
            tail_phase = accepted_count >= command_total - TAIL_COMMANDS;
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (!tail_phase && !steady && $urandom_range(0, 5) == 0) begin
               req_gap = $urandom_range(1, 14) - 1;
               req_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               cmd_on_bus = pending_q.pop_front();
               if ($urandom_range(0, 59) == 0) steady = !steady;
               req_tdata <= REQ_TDATA_W'({cmd_on_bus.lives, cmd_on_bus.level,
                                          cmd_on_bus.key_high, cmd_on_bus.key_mid,
                                          cmd_on_bus.key_low, cmd_on_bus.op});
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if (!tail_phase && !steady && $urandom_range(0, 4) == 0) begin
            rsp_gap = $urandom_range(1, 14) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            accepted_count++;
            op_count[cmd_on_bus.op]++;
            expected_q.push_back(apply_table_command(cmd_on_bus));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected result", '0, 64'(rsp_tdata));
            end else begin
               due = expected_q.pop_front();
               status_count[due.status]++;
               if (rsp_tdata[1:0] !== due.status)
                  report_mismatch("status", 64'(due.status), 64'(rsp_tdata[1:0]));
               if (rsp_tdata[6:2] !== due.slot)
                  report_mismatch("slot_index", 64'(due.slot), 64'(rsp_tdata[6:2]));
               if (rsp_tdata[22:7] !== due.level)
                  report_mismatch("level_out", 64'(due.level), 64'(rsp_tdata[22:7]));
               if (rsp_tdata[30:23] !== due.lives)
                  report_mismatch("lives_out", 64'(due.lives), 64'(rsp_tdata[30:23]));
            end
         end
      end
   end

   initial begin
      int i;
      int roll;
      int phase;
      logic [OP_W-1:0] op;
      for (i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      key_pool[2] = {1'b1, {(KEY_W - 1){1'b0}}};
      key_pool[3] = {{(KEY_W - 1){1'b0}}, 1'b1};
      for (i = 4; i < POOL_SIZE; i++) key_pool[i] = random_key();

      queue_command(OP_INSERT, key_pool[0], 16'h0000, 8'h00);
      queue_command(OP_INSERT, key_pool[1], 16'hffff, 8'hff);
      queue_command(OP_LOOKUP, key_pool[0], 16'h0, 8'h0);
      queue_command(OP_LOOKUP, key_pool[1], 16'h0, 8'h0);
      queue_command(OP_LOOKUP, key_pool[2], 16'h0, 8'h0);
      queue_command(OP_REMOVE, key_pool[3], 16'h0, 8'h0);
      queue_command(OP_INSERT, key_pool[0], 16'h1234, 8'h5a);
      queue_command(OP_LOOKUP, key_pool[0], 16'h0, 8'h0);
      queue_command(OP_REMOVE, key_pool[0], 16'h0, 8'h0);
      queue_command(OP_LOOKUP, key_pool[0], 16'h0, 8'h0);
      queue_command(OP_INSERT, key_pool[2], 16'h00ff, 8'h0f);
      queue_command(OP_SPARE, key_pool[1], 16'hffff, 8'hff);
      queue_command(OP_LOOKUP, key_pool[2], 16'h0, 8'h0);
      queue_command(OP_REMOVE, key_pool[1], 16'h0, 8'h0);
      queue_command(OP_REMOVE, key_pool[1], 16'h0, 8'h0);
      queue_command(OP_LOOKUP, key_pool[1], 16'h0, 8'h0);
      queue_command(OP_INSERT, key_pool[3], 16'h8000, 8'h80);
      queue_command(OP_LOOKUP, key_pool[3], 16'h0, 8'h0);
      queue_command(OP_SPARE, key_pool[0], 16'h0, 8'h0);

      // alternate fill, drain and mixed stretches so the table both fills and empties
      for (i = 0; i < RANDOM_COMMANDS; i++) begin
         phase = (i / 120) % 3;
         roll = $urandom_range(0, 99);
         if (roll >= 95)
            op = OP_SPARE;
         else if (roll < (phase == 0 ? 70 : phase == 1 ? 20 : 40))
            op = OP_INSERT;
         else if (roll < (phase == 0 ? 85 : phase == 1 ? 50 : 70))
            op = OP_LOOKUP;
         else
            op = OP_REMOVE;
         queue_command(op, pick_key(), LEVEL_W'($urandom_range(0, 65535)),
                       LIVES_W'($urandom_range(0, 255)));
      end
      command_total = pending_q.size();

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      while (!(accepted_count == command_total && expected_q.size() == 0))
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d commands: %0d insert, %0d lookup, %0d remove, %0d unused opcode",
               accepted_count, op_count[OP_INSERT], op_count[OP_LOOKUP],
               op_count[OP_REMOVE], op_count[OP_SPARE]);
      $display("results: %0d ok, %0d table full, %0d key not found; %0d mismatches",
               status_count[ST_OK], status_count[ST_FULL], status_count[ST_NOT_FOUND],
               error_count);
      if (error_count == 0)
         $display("keyed_slot_table regression: pass");
      else
         $display("keyed_slot_table regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/kst_pkg.sv
sv/kst_store.sv
sv/kst_scan.sv
sv/keyed_slot_table.sv
verif/tb.sv
